// File: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and codes of the bitmap block allocator
// Request and status codes, controller states, the result beat and
// the free-bit search helper.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int ID_W      = 10;
    localparam int STATUS_W  = 2;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_FULL
    } t_state;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   block_id;
    } t_result;

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: hw/rtl/bba_bitmap_mem.sv
// ----------------------------------------------------------------------------
// bba_bitmap_mem: used-bit storage
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module bba_bitmap_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [bba_pkg::WORD_BITS-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [bba_pkg::WORD_BITS-1:0] o_rd_data
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl: allocator sequencer
// Clears the bitmap after reset, scans words for a free bit on allocate,
// checks and clears a bit on free, and writes the modified word back.
// ----------------------------------------------------------------------------
module bba_ctrl #(
    parameter int NUM_BLOCKS = 1024,
    parameter int NUM_WORDS  = 32,
    parameter int AW         = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [0:0]                    i_action,
    input  logic [bba_pkg::ID_W-1:0]      i_block_id,
    input  logic [bba_pkg::ID_W-1:0]      i_first_data_block,
    input  logic                          i_res_room,
    output logic                          o_res_valid,
    output bba_pkg::t_result              o_res,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [bba_pkg::WORD_BITS-1:0] o_wr_data,
    output logic                          o_rd_en,
    output logic [AW-1:0]                 o_rd_addr,
    input  logic [bba_pkg::WORD_BITS-1:0] i_rd_data
);
    import bba_pkg::*;

    // Wide enough for NUM_BLOCKS itself and for any 10-bit id.
    localparam int IW        = ($clog2(NUM_BLOCKS + 1) > ID_W + 1) ?
                               $clog2(NUM_BLOCKS + 1) : ID_W + 1;
    localparam int LAST_BITS = NUM_BLOCKS - WORD_BITS * (NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] TAIL_MASK = (LAST_BITS == WORD_BITS) ?
        '0 : ~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

    t_state               r_state, n_state;
    logic [AW-1:0]        r_word, n_word;
    logic                 r_first, n_first;
    logic [BIT_W-1:0]     r_sbit, n_sbit;
    logic [ID_W-1:0]      r_id, n_id;
    logic                 r_id_ok, n_id_ok;

    logic                 accept;
    logic [IW-1:0]        fdb_wide, id_wide;
    logic                 fdb_ok, id_ok;
    logic                 is_alloc;
    logic                 last;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] free_vec;
    logic                 found;
    logic [BIT_W-1:0]     bit_pos;
    logic [IW-1:0]        alloc_id;
    logic                 free_hit;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign is_alloc = (t_action'(i_action) == ACT_ALLOC);
    assign fdb_wide = IW'(i_first_data_block);
    assign id_wide  = IW'(i_block_id);
    assign fdb_ok   = fdb_wide < IW'(NUM_BLOCKS);
    assign id_ok    = id_wide < IW'(NUM_BLOCKS);
    assign last     = (r_word == LAST_WORD);

    // Treat bits below the start point and past the end as used.
    assign masked   = i_rd_data
                    | (r_first ? ((WORD_BITS'(1) << r_sbit) - WORD_BITS'(1)) : '0)
                    | (last ? TAIL_MASK : '0);
    assign free_vec = ~masked;
    assign found    = |free_vec;
    assign bit_pos  = lowest_set(free_vec);
    assign alloc_id = IW'({r_word, bit_pos});
    assign free_hit = r_id_ok && i_rd_data[r_id[BIT_W-1:0]];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_CLEAR: begin
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (!is_alloc) begin
                        n_state = S_FREE;
                    end else if (fdb_ok) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FULL;
                    end
                end
            end
            S_SCAN: begin
                if ((found || last) && i_res_room) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE, S_FULL: begin
                if (i_res_room) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs and datapath registers' next values
    always_comb begin
        n_word      = r_word;
        n_first     = r_first;
        n_sbit      = r_sbit;
        n_id        = r_id;
        n_id_ok     = r_id_ok;
        o_in_stall  = 1'b1;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_OK, block_id: '0};
        o_wr_en     = 1'b0;
        o_wr_addr   = r_word;
        o_wr_data   = '0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_word + AW'(1);
        unique case (r_state)
            S_CLEAR: begin
                o_wr_en = 1'b1;
                n_word  = r_word + AW'(1);
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (accept) begin
                    n_id    = i_block_id;
                    n_id_ok = id_ok;
                    n_first = 1'b1;
                    n_sbit  = i_first_data_block[BIT_W-1:0];
                    if (is_alloc) begin
                        n_word    = AW'(fdb_wide >> BIT_W);
                        o_rd_en   = fdb_ok;
                        o_rd_addr = AW'(fdb_wide >> BIT_W);
                    end else begin
                        n_word    = AW'(id_wide >> BIT_W);
                        o_rd_en   = id_ok;
                        o_rd_addr = AW'(id_wide >> BIT_W);
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    o_res_valid = 1'b1;
                    o_res       = '{status: ST_OK, block_id: alloc_id[ID_W-1:0]};
                    o_wr_en     = i_res_room;
                    o_wr_data   = i_rd_data | (WORD_BITS'(1) << bit_pos);
                end else if (last) begin
                    o_res_valid = 1'b1;
                    o_res       = '{status: ST_FULL, block_id: '0};
                end else begin
                    // Fetch the next word while this one is examined.
                    o_rd_en = 1'b1;
                    n_word  = r_word + AW'(1);
                    n_first = 1'b0;
                end
            end
            S_FREE: begin
                o_res_valid = 1'b1;
                o_res       = '{status: (free_hit ? ST_OK : ST_BAD), block_id: r_id};
                o_wr_en     = free_hit && i_res_room;
                o_wr_data   = i_rd_data & ~(WORD_BITS'(1) << r_id[BIT_W-1:0]);
            end
            S_FULL: begin
                o_res_valid = 1'b1;
                o_res       = '{status: ST_FULL, block_id: '0};
            end
            default: begin
                n_word = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_word  <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_sbit  <= n_sbit;
        r_id    <= n_id;
        r_id_ok <= n_id_ok;
    end

endmodule

// File: hw/rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit block allocator over a used-bit map
// Top level: configuration register, output register, controller and
// bitmap memory.
// ----------------------------------------------------------------------------
// One used bit per block lives in a memory of 32-bit words. After reset the
// block clears that memory one word at a time and keeps o_in_stall high
// meanwhile; configuration writes are taken during the clear. An allocate
// beat reads the word holding first_data_block and then one word per cycle
// upward until it finds a clear bit; the single memory read port sets this
// pace. The next beat is taken in the cycle after the result is handed on.
// A free beat reads its word when accepted, then checks the bit and writes
// the word back. A result sits in an output register, so the next request
// is accepted while it waits to be taken; while that register is still full
// the controller holds its result and stalls further requests. When no
// block at or above first_data_block is free, the status is full and the
// block number zero; freeing a block that is out of range or not in use
// reports bad and echoes the block number without touching the map. Write
// first_data_block only while no request is outstanding.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_wr_en,
    input  logic [bba_pkg::ID_W-1:0]     i_cfg_wr_data,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [0:0]                   i_action,
    input  logic [bba_pkg::ID_W-1:0]     i_block_id,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bba_pkg::STATUS_W-1:0] o_status,
    output logic [bba_pkg::ID_W-1:0]     o_block_id_res
);
    import bba_pkg::*;

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam logic [ID_W-1:0] FDB_RESET = 10'd64;

    logic [ID_W-1:0]      r_first_data_block;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic                 res_room;
    logic                 res_valid;
    t_result              res;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    // Configuration register: plain write, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_data_block <= FDB_RESET;
        end else if (i_cfg_wr_en) begin
            r_first_data_block <= i_cfg_wr_data;
        end
    end

    // The output register can take a new beat when empty or being drained.
    assign res_room = !r_out_valid || !i_out_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && res_room) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the payload while the beat is stalled.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_block_id_res = r_out.block_id;

    bba_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .NUM_WORDS  (NUM_WORDS),
        .AW         (AW)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_block_id         (i_block_id),
        .i_first_data_block (r_first_data_block),
        .i_res_room         (res_room),
        .o_res_valid        (res_valid),
        .o_res              (res),
        .o_wr_en            (wr_en),
        .o_wr_addr          (wr_addr),
        .o_wr_data          (wr_data),
        .o_rd_en            (rd_en),
        .o_rd_addr          (rd_addr),
        .i_rd_data          (rd_data)
    );

    bba_bitmap_mem #(
        .DEPTH (NUM_WORDS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
